[rtl/sxsc_pkg.sv]
// Shared types, constants and the control program for the shift-xor stream cipher.
`default_nettype none
package sxsc_pkg;

    localparam int DEFAULT_ROUNDS = 128;
    localparam int WORD_W = 32;
    localparam int PC_W = 5;

    // Configuration register indexes
    localparam logic [1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [1:0] CFG_KEY_LOW  = 2'd1;
    localparam logic [1:0] CFG_IV       = 2'd2;

    // Datapath operations
    localparam logic [2:0] OP_NOP         = 3'd0;
    localparam logic [2:0] OP_LOAD        = 3'd1;
    localparam logic [2:0] OP_ADD_SUM     = 3'd2;
    localparam logic [2:0] OP_WRITE_SHIFT = 3'd3;
    localparam logic [2:0] OP_CLR_ACC     = 3'd4;
    localparam logic [2:0] OP_ADD_ACC     = 3'd5;
    localparam logic [2:0] OP_STEP        = 3'd6;
    localparam logic [2:0] OP_EMIT        = 3'd7;

    // Sequencer conditions
    localparam logic [2:0] COND_NEXT     = 3'd0;
    localparam logic [2:0] COND_DISPATCH = 3'd1;
    localparam logic [2:0] COND_LOOP     = 3'd2;
    localparam logic [2:0] COND_JUMP     = 3'd3;
    localparam logic [2:0] COND_WAIT_OUT = 3'd4;

    // Operand select: shift words 0..3, mix words 4..7
    localparam logic [2:0] SEL_S0 = 3'd0;
    localparam logic [2:0] SEL_S1 = 3'd1;
    localparam logic [2:0] SEL_S2 = 3'd2;
    localparam logic [2:0] SEL_S3 = 3'd3;
    localparam logic [2:0] SEL_M0 = 3'd4;
    localparam logic [2:0] SEL_M1 = 3'd5;
    localparam logic [2:0] SEL_M2 = 3'd6;
    localparam logic [2:0] SEL_M3 = 3'd7;

    // Program entry points
    localparam logic [PC_W-1:0] PC_IDLE  = 5'd0;
    localparam logic [PC_W-1:0] PC_INIT  = 5'd1;
    localparam logic [PC_W-1:0] PC_LOOP  = 5'd6;
    localparam logic [PC_W-1:0] PC_CRYPT = 5'd16;

    typedef struct packed {
        logic [2:0]      op;
        logic [2:0]      sel;
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    typedef struct packed {
        logic accept;
        logic cmd;
        logic loop_last;
        logic out_free;
    } seq_status_t;

    function automatic ctrl_word_t cw(input logic [2:0] op, input logic [2:0] sel,
                                      input logic [2:0] cond,
                                      input logic [PC_W-1:0] target);
        ctrl_word_t w;
        w.op     = op;
        w.sel    = sel;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    function automatic ctrl_word_t rom_word(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        unique case (pc)
            5'd0:    w = cw(OP_NOP,         SEL_S0, COND_DISPATCH, PC_IDLE);
            5'd1:    w = cw(OP_LOAD,        SEL_S0, COND_NEXT,     PC_IDLE);
            5'd2:    w = cw(OP_ADD_SUM,     SEL_S0, COND_NEXT,     PC_IDLE);
            5'd3:    w = cw(OP_ADD_SUM,     SEL_S1, COND_NEXT,     PC_IDLE);
            5'd4:    w = cw(OP_ADD_SUM,     SEL_S2, COND_NEXT,     PC_IDLE);
            5'd5:    w = cw(OP_ADD_SUM,     SEL_S3, COND_NEXT,     PC_IDLE);
            5'd6:    w = cw(OP_ADD_SUM,     SEL_S0, COND_NEXT,     PC_IDLE);
            5'd7:    w = cw(OP_ADD_SUM,     SEL_S1, COND_NEXT,     PC_IDLE);
            5'd8:    w = cw(OP_ADD_SUM,     SEL_S2, COND_NEXT,     PC_IDLE);
            5'd9:    w = cw(OP_ADD_SUM,     SEL_S3, COND_NEXT,     PC_IDLE);
            5'd10:   w = cw(OP_WRITE_SHIFT, SEL_S0, COND_LOOP,     PC_LOOP);
            5'd11:   w = cw(OP_CLR_ACC,     SEL_S0, COND_NEXT,     PC_IDLE);
            5'd12:   w = cw(OP_ADD_ACC,     SEL_S0, COND_NEXT,     PC_IDLE);
            5'd13:   w = cw(OP_ADD_ACC,     SEL_S1, COND_NEXT,     PC_IDLE);
            5'd14:   w = cw(OP_ADD_ACC,     SEL_S2, COND_NEXT,     PC_IDLE);
            5'd15:   w = cw(OP_ADD_ACC,     SEL_S3, COND_JUMP,     PC_IDLE);
            5'd16:   w = cw(OP_STEP,        SEL_S0, COND_NEXT,     PC_IDLE);
            5'd17:   w = cw(OP_ADD_ACC,     SEL_S0, COND_NEXT,     PC_IDLE);
            5'd18:   w = cw(OP_ADD_ACC,     SEL_S1, COND_NEXT,     PC_IDLE);
            5'd19:   w = cw(OP_ADD_ACC,     SEL_S2, COND_NEXT,     PC_IDLE);
            5'd20:   w = cw(OP_ADD_ACC,     SEL_S3, COND_NEXT,     PC_IDLE);
            5'd21:   w = cw(OP_ADD_ACC,     SEL_M0, COND_NEXT,     PC_IDLE);
            5'd22:   w = cw(OP_ADD_ACC,     SEL_M1, COND_NEXT,     PC_IDLE);
            5'd23:   w = cw(OP_ADD_ACC,     SEL_M2, COND_NEXT,     PC_IDLE);
            5'd24:   w = cw(OP_ADD_ACC,     SEL_M3, COND_NEXT,     PC_IDLE);
            5'd25:   w = cw(OP_EMIT,        SEL_S0, COND_WAIT_OUT, PC_IDLE);
            default: w = cw(OP_NOP,         SEL_S0, COND_JUMP,     PC_IDLE);
        endcase
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] mix_a(input logic [WORD_W-1:0] v);
        return (v << 4) ^ (v << 3) ^ (v >> 4) ^ (v >> 3);
    endfunction

    function automatic logic [WORD_W-1:0] mix_b(input logic [WORD_W-1:0] v);
        return (v << 3) ^ (v << 2) ^ (v >> 4) ^ (v >> 1);
    endfunction

    function automatic logic [WORD_W-1:0] mix_c(input logic [WORD_W-1:0] v);
        return (v << 1) ^ (v << 2) ^ (v >> 3) ^ (v >> 1);
    endfunction

    function automatic logic [WORD_W-1:0] mix_d(input logic [WORD_W-1:0] v);
        return (v << 2) ^ (v << 5) ^ (v >> 4) ^ (v >> 2);
    endfunction

endpackage
`default_nettype wire

[rtl/sxsc_seq.sv]
// Microcode sequencer: step counter, control ROM and jump logic.
`default_nettype none
module sxsc_seq (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire sxsc_pkg::seq_status_t status,
    output sxsc_pkg::ctrl_word_t ctrl,
    output logic                 in_ready
);
    import sxsc_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;

    assign ctrl     = rom_word(pc_reg);
    assign in_ready = (pc_reg == PC_IDLE);

    always_comb
    begin
        unique case (ctrl.cond)
            COND_NEXT:     pc_next = pc_reg + 1'b1;
            COND_DISPATCH:
            begin
                if (status.accept)
                    pc_next = status.cmd ? PC_CRYPT : PC_INIT;
                else
                    pc_next = pc_reg;
            end
            COND_LOOP:     pc_next = status.loop_last ? pc_reg + 1'b1 : ctrl.target;
            COND_JUMP:     pc_next = ctrl.target;
            COND_WAIT_OUT: pc_next = status.out_free ? ctrl.target : pc_reg;
            default:       pc_next = PC_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= PC_IDLE;
        else
            pc_reg <= pc_next;
    end

    // Hold the emit step until the output slot frees up
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_EMIT && !status.out_free) |=> (pc_reg == $past(pc_reg)))
        else $error("emit step left before output slot was free");

    // Leave idle only on an accepted word
    a_idle_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == PC_IDLE && !status.accept) |=> (pc_reg == PC_IDLE))
        else $error("sequencer left idle without a word");

endmodule
`default_nettype wire

[rtl/shift_xor_stream_cipher.sv]
// Top level of the shift-xor stream cipher: config registers, datapath and output register.
`default_nettype none
// Shift-xor stream cipher. Load key_high, key_low and init_vector through the
// config port (indexes 0, 1, 2) while the block is idle, then send a word with
// cmd = 0 to run the key schedule, and words with cmd = 1 to encrypt or decrypt
// up to four bytes each (first byte in bits 7..0, valid_bytes of them XORed
// with keystream, the rest passed through; valid_bytes of 4 or more means all
// four, 0 means none). An init word returns nothing; a crypt word returns one
// data_out word. All work runs through one shared 32-bit adder driven by a
// short microcode program, one operand per cycle. An init word keeps the input
// side busy through 4*SCHEDULE_ROUNDS schedule updates, each adding the four
// shift words to a running sum and writing it into a shift word; a crypt word
// runs a crypt step, eight adder steps into the accumulator and its emit step.
// A finished result waits in an output register, and the next word is taken as it waits.
module shift_xor_stream_cipher #(
    parameter int SCHEDULE_ROUNDS = sxsc_pkg::DEFAULT_ROUNDS
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [63:0] cfg_data,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire         cmd,
    input  wire  [31:0] data_in,
    input  wire  [2:0]  valid_bytes,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [31:0] data_out
);
    import sxsc_pkg::*;

    localparam int LOOP_COUNT = 4 * SCHEDULE_ROUNDS;
    localparam int ITER_W = $clog2(LOOP_COUNT);
    localparam logic [ITER_W-1:0] LOOP_LAST = ITER_W'(LOOP_COUNT - 1);

    ctrl_word_t  ctrl;
    seq_status_t status;
    logic        in_accept;

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic [63:0] iv_reg;

    logic [WORD_W-1:0] shift_reg [4];
    logic [WORD_W-1:0] mix_reg [4];
    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] sum_reg;
    logic [ITER_W-1:0] iter_reg;

    logic [WORD_W-1:0] data_reg;
    logic [2:0]        vb_reg;
    logic              out_valid_reg;
    logic [WORD_W-1:0] data_out_reg;

    logic [WORD_W-1:0] operand;
    logic [WORD_W-1:0] add_base;
    logic [WORD_W-1:0] add_result;
    logic [WORD_W-1:0] s_next [4];
    logic [WORD_W-1:0] m_next [4];
    logic [WORD_W-1:0] keystream;
    logic [WORD_W-1:0] byte_mask;
    logic              out_free;

    assign cfg_ready = 1'b1;
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign status.accept    = in_accept;
    assign status.cmd       = cmd;
    assign status.loop_last = (iter_reg == LOOP_LAST);
    assign status.out_free  = out_free;

    sxsc_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .status   (status),
        .ctrl     (ctrl),
        .in_ready (in_ready)
    );

    // Config registers; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            iv_reg       <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_KEY_HIGH)
                key_high_reg <= cfg_data;
            if (cfg_index == CFG_KEY_LOW)
                key_low_reg <= cfg_data;
            if (cfg_index == CFG_IV)
                iv_reg <= cfg_data;
        end
    end

    // Shared adder: one selected word into the schedule sum or the accumulator
    always_comb
    begin
        unique case (ctrl.sel)
            SEL_S0:  operand = shift_reg[0];
            SEL_S1:  operand = shift_reg[1];
            SEL_S2:  operand = shift_reg[2];
            SEL_S3:  operand = shift_reg[3];
            SEL_M0:  operand = mix_reg[0];
            SEL_M1:  operand = mix_reg[1];
            SEL_M2:  operand = mix_reg[2];
            SEL_M3:  operand = mix_reg[3];
            default: operand = shift_reg[0];
        endcase
    end

    assign add_base   = (ctrl.op == OP_ADD_ACC) ? acc_reg : sum_reg;
    assign add_result = add_base + operand;

    // Crypt step: registers update in chain order, register 3 xors with itself
    always_comb
    begin
        s_next[0] = mix_a(shift_reg[0]) ^ mix_reg[3];
        s_next[1] = mix_b(shift_reg[1]) ^ mix_reg[2];
        s_next[2] = mix_c(shift_reg[2]) ^ mix_reg[1];
        s_next[3] = mix_d(shift_reg[3]) ^ shift_reg[3];
        m_next[3] = mix_a(mix_reg[3]) ^ s_next[0];
        m_next[2] = mix_b(mix_reg[2]) ^ s_next[1];
        m_next[0] = mix_c(mix_reg[0]) ^ s_next[2];
        m_next[1] = mix_d(mix_reg[1]) ^ m_next[0];
    end

    assign keystream = shift_reg[0] ^ shift_reg[1] ^ shift_reg[2] ^ shift_reg[3] ^ acc_reg
                     ^ mix_reg[0] ^ mix_reg[1] ^ mix_reg[2] ^ mix_reg[3];

    always_comb
    begin
        unique case (vb_reg)
            3'd0:    byte_mask = 32'h0000_0000;
            3'd1:    byte_mask = 32'h0000_00FF;
            3'd2:    byte_mask = 32'h0000_FFFF;
            3'd3:    byte_mask = 32'h00FF_FFFF;
            default: byte_mask = 32'hFFFF_FFFF;
        endcase
    end

    // Cipher state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                shift_reg[i] <= '0;
                mix_reg[i]   <= '0;
            end
            acc_reg  <= '0;
            sum_reg  <= '0;
            iter_reg <= '0;
        end
        else
        begin
            unique case (ctrl.op)
                OP_LOAD:
                begin
                    shift_reg[0] <= key_high_reg[63:32];
                    shift_reg[1] <= key_high_reg[31:0];
                    shift_reg[2] <= key_low_reg[63:32] ^ iv_reg[63:32];
                    shift_reg[3] <= key_low_reg[31:0] ^ iv_reg[31:0];
                    mix_reg[0]   <= key_high_reg[63:32];
                    mix_reg[1]   <= key_high_reg[31:0];
                    mix_reg[2]   <= key_low_reg[63:32] ^ iv_reg[63:32];
                    mix_reg[3]   <= key_low_reg[31:0] ^ iv_reg[31:0];
                    sum_reg      <= 32'h0000_0001;
                    iter_reg     <= '0;
                end
                OP_ADD_SUM:
                    sum_reg <= add_result;
                OP_WRITE_SHIFT:
                begin
                    shift_reg[iter_reg[1:0]] <= sum_reg;
                    iter_reg <= iter_reg + 1'b1;
                end
                OP_CLR_ACC:
                    acc_reg <= '0;
                OP_ADD_ACC:
                    acc_reg <= add_result;
                OP_STEP:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        shift_reg[i] <= s_next[i];
                        mix_reg[i]   <= m_next[i];
                    end
                end
                OP_NOP, OP_EMIT:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // Hold the accepted word's payload for the emit step
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            data_reg <= data_in;
            vb_reg   <= valid_bytes;
        end
    end

    // Output register: fill on emit, drop on handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.op == OP_EMIT && out_free)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.op == OP_EMIT && out_free)
            data_out_reg <= data_reg ^ (keystream & byte_mask);
    end

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;

    // A result appears only from the emit step
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctrl.op == OP_EMIT))
        else $error("result appeared without an emit step");

    // A crypt word keeps the input side busy for the next cycle
    a_crypt_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && cmd) |=> !in_ready)
        else $error("input ready right after a crypt word");

    // Schedule load restarts the update counter
    a_load_iter: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_LOAD) |=> (iter_reg == '0))
        else $error("update counter not cleared by schedule load");

endmodule
`default_nettype wire
